// ----- rtl/core/cfsc_pkg.sv -----
package cfsc_pkg;

  localparam int CFSC_TABLE_ENTRIES = 16;
  localparam logic [31:0] CFSC_ROOT_RESET = 32'h0000_0001;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_CHECK = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_RESTART   = 3'd1,
    ST_VIOLATION = 3'd2,
    ST_BAD_ENTRY = 3'd3,
    ST_MISSING   = 3'd4
  } cfsc_status_e;

  // Which id a table scan searches for.
  typedef enum logic [1:0] {
    KEY_POS  = 2'd0,
    KEY_ROOT = 2'd1,
    KEY_SIG  = 2'd2
  } cfsc_key_e;

  // How the position register moves when a result is set.
  typedef enum logic [1:0] {
    POS_KEEP = 2'd0,
    POS_ROOT = 2'd1,
    POS_SIG  = 2'd2
  } cfsc_pos_e;

  typedef struct packed {
    logic [31:0] node;
    logic [1:0]  count;
    logic [31:0] next_a;
    logic [31:0] next_b;
  } cfsc_entry_t;

  typedef struct packed {
    logic         capture;
    logic         load_wr;
    logic         scan_start;
    cfsc_key_e    key_sel;
    logic         res_we;
    cfsc_status_e res_status;
    cfsc_pos_e    pos_sel;
    logic         out_load;
  } cfsc_cmd_t;

  typedef struct packed {
    logic       scan_done;
    logic       found;
    logic [1:0] count;
    logic       match_a;
    logic       match_b;
  } cfsc_stat_t;

endpackage

// ----- rtl/core/cfsc_in_if.sv -----
interface cfsc_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [3:0]  entry_index;
  logic [31:0] node_id;
  logic [1:0]  succ_count;
  logic [31:0] succ_first;
  logic [31:0] succ_second;

  modport source (
    output valid, req_type, entry_index, node_id, succ_count, succ_first, succ_second,
    input  ready
  );
  modport sink (
    input  valid, req_type, entry_index, node_id, succ_count, succ_first, succ_second,
    output ready
  );
endinterface

// ----- rtl/core/cfsc_out_if.sv -----
interface cfsc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  check_status;
  logic [31:0] current_node;

  modport source (
    output valid, check_status, current_node,
    input  ready
  );
  modport sink (
    input  valid, check_status, current_node,
    output ready
  );
endinterface

// ----- rtl/core/cfsc_cfg_if.sv -----
interface cfsc_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (
    output valid, data,
    input  ready
  );
  modport sink (
    input  valid, data,
    output ready
  );
endinterface

// ----- rtl/core/cfsc_ram.sv -----
module cfsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/cfsc_datapath.sv -----
module cfsc_datapath
  import cfsc_pkg::*;
#(
  parameter int TABLE_ENTRIES = CFSC_TABLE_ENTRIES
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cfsc_cmd_t    cmd_i,
  output cfsc_stat_t   stat_o,
  input  logic [3:0]   entry_index_i,
  input  logic [31:0]  node_id_i,
  input  logic [1:0]   succ_count_i,
  input  logic [31:0]  succ_first_i,
  input  logic [31:0]  succ_second_i,
  input  logic         cfg_we_i,
  input  logic [31:0]  cfg_data_i,
  output cfsc_status_e out_status_o,
  output logic [31:0]  out_node_o
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_ENTRIES - 1);

  logic [31:0]      root_q;
  logic [31:0]      position_q;
  logic [31:0]      sig_q;
  logic [31:0]      key_q;
  logic [31:0]      key_d;
  logic [IDX_W-1:0] addr_q;
  logic [IDX_W-1:0] pend_q;
  logic             busy_q;
  logic             rd_pend_q;
  logic             done_q;
  logic             found_q;
  logic [1:0]       count_q;
  logic [31:0]      next_a_q;
  logic [31:0]      next_b_q;
  logic [TABLE_ENTRIES-1:0] valid_q;
  cfsc_status_e     status_q;
  cfsc_status_e     out_status_q;
  logic [31:0]      out_node_q;

  logic             in_range;
  logic             ram_we;
  logic [IDX_W-1:0] waddr;
  cfsc_entry_t      wentry;
  cfsc_entry_t      rentry;
  logic             hit;
  logic             scan_end;

  assign in_range = (32'(entry_index_i) < TABLE_ENTRIES);
  assign ram_we   = cmd_i.load_wr && in_range;
  assign waddr    = IDX_W'(entry_index_i);
  assign wentry   = '{node: node_id_i, count: succ_count_i,
                      next_a: succ_first_i, next_b: succ_second_i};

  cfsc_ram #(
    .WIDTH ($bits(cfsc_entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (wentry),
    .re_i    (busy_q),
    .raddr_i (addr_q),
    .rdata_o (rentry)
  );

  always_comb begin
    unique case (cmd_i.key_sel)
      KEY_POS:  key_d = position_q;
      KEY_ROOT: key_d = root_q;
      KEY_SIG:  key_d = sig_q;
      default:  key_d = position_q;
    endcase
  end

  // The registered RAM read of slot pend_q is compared here; the lowest match stops the scan.
  assign hit      = rd_pend_q && valid_q[pend_q] && (rentry.node == key_q);
  assign scan_end = rd_pend_q && (hit || (pend_q == LAST));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q     <= CFSC_ROOT_RESET;
      position_q <= CFSC_ROOT_RESET;
      valid_q    <= '0;
      busy_q     <= 1'b0;
      rd_pend_q  <= 1'b0;
      done_q     <= 1'b0;
      addr_q     <= '0;
      pend_q     <= '0;
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) begin
        root_q <= cfg_data_i;
      end
      if (ram_we) begin
        valid_q[waddr] <= 1'b1;
      end
      if (cmd_i.scan_start) begin
        busy_q    <= 1'b1;
        rd_pend_q <= 1'b0;
        addr_q    <= '0;
      end else if (busy_q) begin
        if (scan_end) begin
          busy_q    <= 1'b0;
          rd_pend_q <= 1'b0;
          done_q    <= 1'b1;
        end else begin
          rd_pend_q <= 1'b1;
          pend_q    <= addr_q;
          addr_q    <= (addr_q == LAST) ? addr_q : addr_q + 1'b1;
        end
      end
      if (cmd_i.res_we) begin
        unique case (cmd_i.pos_sel)
          POS_KEEP: position_q <= position_q;
          POS_ROOT: position_q <= root_q;
          POS_SIG:  position_q <= sig_q;
          default:  position_q <= root_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sig_q <= node_id_i;
    end
    if (cmd_i.scan_start) begin
      key_q <= key_d;
    end
    if (busy_q && scan_end) begin
      found_q  <= hit;
      count_q  <= rentry.count;
      next_a_q <= rentry.next_a;
      next_b_q <= rentry.next_b;
    end
    if (cmd_i.res_we) begin
      status_q <= cmd_i.res_status;
    end
    if (cmd_i.out_load) begin
      out_status_q <= status_q;
      out_node_q   <= position_q;
    end
  end

  assign stat_o = '{scan_done: done_q, found: found_q, count: count_q,
                    match_a: (next_a_q == sig_q), match_b: (next_b_q == sig_q)};

  assign out_status_o = out_status_q;
  assign out_node_o   = out_node_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("scan done raised while the scan is still busy");

  a_last_slot_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && rd_pend_q && (pend_q == LAST) && !cmd_i.scan_start) |=> (!busy_q && done_q))
    else $error("scan ran past the last slot");

  a_start_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_start |=> (busy_q && !rd_pend_q && (addr_q == '0)))
    else $error("scan did not restart from slot zero");

endmodule

// ----- rtl/core/cfsc_ctrl.sv -----
module cfsc_ctrl
  import cfsc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_req_type_i,
  output logic       in_ready_o,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  input  cfsc_stat_t stat_i,
  output cfsc_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_CUR,
    S_SCAN_ROOT,
    S_SCAN_SUCC,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   restart_q, restart_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o            = '0;
    cmd_o.key_sel    = KEY_POS;
    cmd_o.res_status = ST_OK;
    cmd_o.pos_sel    = POS_KEEP;
    state_d          = state_q;
    restart_d        = restart_q;
    out_valid_d      = out_valid_q && !out_ready_i;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.capture = 1'b1;
          if (in_req_type_i == REQ_LOAD) begin
            cmd_o.load_wr = 1'b1;
            cmd_o.res_we  = 1'b1;
            state_d       = S_FINISH;
          end else begin
            cmd_o.scan_start = 1'b1;
            cmd_o.key_sel    = KEY_POS;
            state_d          = S_SCAN_CUR;
          end
        end
      end
      S_SCAN_CUR: begin
        if (stat_i.scan_done) begin
          cmd_o.pos_sel = POS_ROOT;
          priority if (!stat_i.found) begin
            cmd_o.res_we     = 1'b1;
            cmd_o.res_status = ST_BAD_ENTRY;
            state_d          = S_FINISH;
          end else if (stat_i.count == 2'd0) begin
            // Program end: look up the root and check against its successor.
            cmd_o.scan_start = 1'b1;
            cmd_o.key_sel    = KEY_ROOT;
            state_d          = S_SCAN_ROOT;
          end else if (stat_i.count == 2'd3) begin
            cmd_o.res_we     = 1'b1;
            cmd_o.res_status = ST_BAD_ENTRY;
            state_d          = S_FINISH;
          end else if (stat_i.match_a || (stat_i.count == 2'd2 && stat_i.match_b)) begin
            cmd_o.scan_start = 1'b1;
            cmd_o.key_sel    = KEY_SIG;
            restart_d        = 1'b0;
            state_d          = S_SCAN_SUCC;
          end else begin
            cmd_o.res_we     = 1'b1;
            cmd_o.res_status = ST_VIOLATION;
            state_d          = S_FINISH;
          end
        end
      end
      S_SCAN_ROOT: begin
        if (stat_i.scan_done) begin
          cmd_o.pos_sel = POS_ROOT;
          priority if (!stat_i.found || stat_i.count != 2'd1) begin
            cmd_o.res_we     = 1'b1;
            cmd_o.res_status = ST_BAD_ENTRY;
            state_d          = S_FINISH;
          end else if (!stat_i.match_a) begin
            cmd_o.res_we     = 1'b1;
            cmd_o.res_status = ST_VIOLATION;
            state_d          = S_FINISH;
          end else begin
            cmd_o.scan_start = 1'b1;
            cmd_o.key_sel    = KEY_SIG;
            restart_d        = 1'b1;
            state_d          = S_SCAN_SUCC;
          end
        end
      end
      S_SCAN_SUCC: begin
        if (stat_i.scan_done) begin
          cmd_o.res_we = 1'b1;
          state_d      = S_FINISH;
          if (stat_i.found) begin
            cmd_o.res_status = restart_q ? ST_RESTART : ST_OK;
            cmd_o.pos_sel    = POS_SIG;
          end else begin
            cmd_o.res_status = ST_MISSING;
            cmd_o.pos_sel    = POS_ROOT;
          end
        end
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      restart_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      restart_q   <= restart_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("output word overwritten before it was taken");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != S_IDLE))
    else $error("accepted word did not start any work");

  a_done_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.scan_done |-> (state_q == S_SCAN_CUR || state_q == S_SCAN_ROOT ||
                          state_q == S_SCAN_SUCC))
    else $error("scan finished while no scan was running");

endmodule

// ----- rtl/core/control_flow_signature_checker_top.sv -----
// Control-flow signature checker.
// Words arrive on in_i. A load word (req_type 0) writes one table entry: node id,
// successor count and two successor ids. A check word (req_type 1) carries the
// signature of the basic block just entered and is tested against the successors
// of the node the checker stands on. Every word gives exactly one result word
// on out_o: a status code and the node the checker stands on afterwards.
// cfg_i writes the root node id; it is always ready.
// A check runs one to three sequential scans of the table RAM, one slot per cycle;
// one word is in work at a time and in_i is ready again once its result is in the
// output register.
// At reset all table entries become invalid and the position and the root id are
// both node 1. When out_o stalls, the finished result waits in the output
// register; the next word may be accepted, and its result is held internally
// until the output register is free.
module control_flow_signature_checker_top
  import cfsc_pkg::*;
#(
  parameter int TABLE_ENTRIES = CFSC_TABLE_ENTRIES
) (
  input  logic clk_i,
  input  logic rst_ni,
  cfsc_in_if.sink    in_i,
  cfsc_cfg_if.sink   cfg_i,
  cfsc_out_if.source out_o
);

  cfsc_cmd_t    cmd;
  cfsc_stat_t   stat;
  cfsc_status_e out_status;

  assign cfg_i.ready = 1'b1;

  cfsc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_req_type_i (in_i.req_type),
    .in_ready_o    (in_i.ready),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  cfsc_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .entry_index_i (in_i.entry_index),
    .node_id_i     (in_i.node_id),
    .succ_count_i  (in_i.succ_count),
    .succ_first_i  (in_i.succ_first),
    .succ_second_i (in_i.succ_second),
    .cfg_we_i      (cfg_i.valid),
    .cfg_data_i    (cfg_i.data),
    .out_status_o  (out_status),
    .out_node_o    (out_o.current_node)
  );

  assign out_o.check_status = out_status;

endmodule
